@@ design/fuel_pump_prime_sequencer_assert.svh @@
// Assertion macros used by the fuel pump prime sequencer checker.
`ifndef FUEL_PUMP_PRIME_SEQUENCER_ASSERT_SVH
`define FUEL_PUMP_PRIME_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, ignored while in reset.
`define FPPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpps assertion failed");

// Next-cycle implication, sampled on clk, ignored while in reset.
`define FPPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpps assertion failed");

`endif

@@ design/fpps_pkg.sv @@
// Types and constants of the fuel pump prime sequencer.
package fpps_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_RUN_SPEED  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_TIME    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_TIME   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ANTIC_CODE = 4'd3;

    localparam logic [15:0] PHASE_MAX = 16'd65000;

    typedef enum logic [2:0] {
        SEQ_WAIT  = 3'd0,
        SEQ_STALL = 3'd1,
        SEQ_NOM   = 3'd2,
        SEQ_REST  = 3'd3,
        SEQ_ON    = 3'd4,
        SEQ_KEYON = 3'd5
    } seq_t;

    typedef struct packed {
        logic [7:0]  run_speed;
        logic [15:0] on_time;
        logic [15:0] off_time;
        logic [3:0]  antic_code;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  seq_state;
        logic [15:0] phase_count;
        logic        pump_cmd;
        logic        precontrol_flag;
        logic        init_done;
        logic        after_stall;
    } state_t;

    typedef struct packed {
        logic [7:0] engine_speed;
        logic [7:0] speed_threshold;
        logic [3:0] power_state;
        logic       prep_request;
        logic       key_on;
        logic [7:0] pump_count;
        logic       precontrol_active;
        logic       set_after_stall;
        logic       set_init_done;
    } tick_t;

    // Phase length clamped to 1..PHASE_MAX, minus one.
    function automatic logic [15:0] phase_load(input logic [15:0] len);
        logic [15:0] r;
        if (len == 16'd0)
            r = 16'd0;
        else if (len > PHASE_MAX)
            r = PHASE_MAX - 16'd1;
        else
            r = len - 16'd1;
        return r;
    endfunction

    // Saturating decrement, limited to PHASE_MAX.
    function automatic logic [15:0] count_down(input logic [15:0] c);
        logic [15:0] d;
        d = c - 16'd1;
        if (c == 16'd0)
            d = 16'd0;
        else if (d > PHASE_MAX)
            d = PHASE_MAX;
        return d;
    endfunction

endpackage

@@ design/fpps_step.sv @@
// One tick of the priming sequencer: next state and enable from state and tick word.
module fpps_step (
    input  fpps_pkg::cfg_t   cfg,
    input  fpps_pkg::state_t cur,
    input  fpps_pkg::tick_t  tick,
    output fpps_pkg::state_t nxt,
    output logic             periodic_enable
);
    import fpps_pkg::*;

    logic running;
    logic remote;
    logic enable;
    logic as_pre;
    logic id_pre;
    logic pf_pre;
    logic pc_pre;

    assign as_pre  = cur.after_stall | tick.set_after_stall;
    assign id_pre  = cur.init_done | tick.set_init_done;
    assign pf_pre  = cur.precontrol_flag | (tick.engine_speed > tick.speed_threshold);
    assign running = tick.engine_speed > cfg.run_speed;
    assign remote  = (tick.power_state == cfg.antic_code) && tick.prep_request;
    assign enable  = !running && (remote || tick.key_on);
    // Running forces on; no key and no anticipation forces off.
    assign pc_pre  = (cur.pump_cmd | running) & (remote | tick.key_on);

    assign periodic_enable = enable;

    always_comb
    begin
        nxt.seq_state       = cur.seq_state;
        nxt.phase_count     = cur.phase_count;
        nxt.pump_cmd        = pc_pre;
        nxt.precontrol_flag = pf_pre;
        nxt.init_done       = id_pre;
        nxt.after_stall     = as_pre;
        case (cur.seq_state)
            SEQ_WAIT:
            begin
                if (enable && tick.pump_count == 8'd0 && tick.precontrol_active)
                begin
                    if (as_pre)
                    begin
                        nxt.seq_state   = SEQ_STALL;
                        nxt.phase_count = count_down(cur.phase_count);
                    end
                    else if (id_pre)
                    begin
                        nxt.seq_state   = SEQ_NOM;
                        nxt.phase_count = count_down(cur.phase_count);
                    end
                    else
                    begin
                        nxt.seq_state   = SEQ_KEYON;
                        nxt.pump_cmd    = 1'b1;
                        nxt.phase_count = phase_load(cfg.on_time);
                    end
                end
            end
            SEQ_STALL, SEQ_NOM, SEQ_REST, SEQ_ON, SEQ_KEYON:
            begin
                if (!enable || cur.phase_count == 16'd0)
                begin
                    // Leaving stall or nominal drops their flags.
                    if (cur.seq_state == SEQ_STALL)
                        nxt.after_stall = 1'b0;
                    if (cur.seq_state == SEQ_NOM)
                    begin
                        nxt.precontrol_flag = 1'b0;
                        nxt.init_done       = 1'b0;
                    end
                end
                if (!enable)
                begin
                    nxt.phase_count = 16'd0;
                    nxt.seq_state   = SEQ_WAIT;
                end
                else if (cur.phase_count == 16'd0)
                begin
                    if (cur.seq_state == SEQ_REST)
                    begin
                        nxt.pump_cmd    = 1'b1;
                        nxt.seq_state   = SEQ_ON;
                        nxt.phase_count = phase_load(cfg.on_time);
                    end
                    else
                    begin
                        nxt.pump_cmd    = 1'b0;
                        nxt.seq_state   = SEQ_REST;
                        nxt.phase_count = phase_load(cfg.off_time);
                    end
                end
                else
                begin
                    nxt.phase_count = count_down(cur.phase_count);
                end
            end
            default:
            begin
                nxt.seq_state = SEQ_WAIT;
            end
        endcase
    end

endmodule

@@ design/fuel_pump_prime_sequencer.sv @@
// Top level of the fuel pump prime sequencer.
// Each accepted input word is one task tick; its result word appears in the output
// register on the next clock and is held until taken. One word is accepted every
// clock while the input is not stalled: the state update and result are one short
// combinational step from the held sequencer state. The input stalls only while a
// result is waiting and the output is stalled. Configuration writes take effect at
// once; the user must make them while the block is idle (not enforced here).
module fuel_pump_prime_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fpps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fpps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          engine_speed,
    input  logic [7:0]                          speed_threshold,
    input  logic [3:0]                          power_state,
    input  logic                                prep_request,
    input  logic                                key_on,
    input  logic [7:0]                          pump_count,
    input  logic                                precontrol_active,
    input  logic                                set_after_stall,
    input  logic                                set_init_done,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pump_on,
    output logic                                periodic_enable,
    output logic                                precontrol_ok,
    output logic [2:0]                          sequencer_state,
    output logic [15:0]                         ticks_left,
    output logic                                init_done_flag,
    output logic                                after_stall_flag
);
    import fpps_pkg::*;

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    tick_t  tick;
    logic   enable_next;
    logic   enable_reg;
    logic   out_valid_reg;
    logic   in_accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign tick.engine_speed      = engine_speed;
    assign tick.speed_threshold   = speed_threshold;
    assign tick.power_state       = power_state;
    assign tick.prep_request      = prep_request;
    assign tick.key_on            = key_on;
    assign tick.pump_count        = pump_count;
    assign tick.precontrol_active = precontrol_active;
    assign tick.set_after_stall   = set_after_stall;
    assign tick.set_init_done     = set_init_done;

    fpps_step u_step (
        .cfg             (cfg_reg),
        .cur             (state_reg),
        .tick            (tick),
        .nxt             (state_next),
        .periodic_enable (enable_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_speed  <= 8'd0;
            cfg_reg.on_time    <= 16'd1;
            cfg_reg.off_time   <= 16'd1;
            cfg_reg.antic_code <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RUN_SPEED:  cfg_reg.run_speed  <= cfg_data[7:0];
                REG_ON_TIME:    cfg_reg.on_time    <= cfg_data;
                REG_OFF_TIME:   cfg_reg.off_time   <= cfg_data;
                REG_ANTIC_CODE: cfg_reg.antic_code <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // The state itself is the result word, so it doubles as the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.seq_state       <= SEQ_WAIT;
            state_reg.phase_count     <= 16'd0;
            state_reg.pump_cmd        <= 1'b0;
            state_reg.precontrol_flag <= 1'b0;
            state_reg.init_done       <= 1'b0;
            state_reg.after_stall     <= 1'b0;
            enable_reg                <= 1'b0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg  <= state_next;
                enable_reg <= enable_next;
            end
            // Hold the word until taken; a new one replaces it in the same cycle.
            out_valid_reg <= in_accept || (out_valid_reg && out_stall);
        end
    end

    assign out_valid        = out_valid_reg;
    assign pump_on          = state_reg.pump_cmd;
    assign periodic_enable  = enable_reg;
    assign precontrol_ok    = state_reg.precontrol_flag;
    assign sequencer_state  = state_reg.seq_state;
    assign ticks_left       = state_reg.phase_count;
    assign init_done_flag   = state_reg.init_done;
    assign after_stall_flag = state_reg.after_stall;

endmodule

@@ design/fpps_checker.sv @@
// Port-level checks of the fuel pump prime sequencer, bound to the top level.
`include "fuel_pump_prime_sequencer_assert.svh"

module fpps_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                pump_on,
    input  logic                                periodic_enable,
    input  logic                                precontrol_ok,
    input  logic [2:0]                          sequencer_state,
    input  logic [15:0]                         ticks_left,
    input  logic                                init_done_flag,
    input  logic                                after_stall_flag
);
    import fpps_pkg::*;

    logic        on_phase;
    logic [23:0] word_bits;

    assign on_phase  = (sequencer_state == SEQ_ON) || (sequencer_state == SEQ_KEYON);
    assign word_bits = {pump_on, periodic_enable, precontrol_ok, sequencer_state,
                        ticks_left, init_done_flag, after_stall_flag};

    // Waiting always sits with a cleared counter.
    `FPPS_ASSERT_NOW(a_wait_clear, out_valid && sequencer_state == SEQ_WAIT, ticks_left == 16'd0)

    // Without enable the sequencer falls back to waiting.
    `FPPS_ASSERT_NOW(a_enable_wait, out_valid && !periodic_enable, sequencer_state == SEQ_WAIT)

    // On phases drive the pump, rest keeps it off.
    `FPPS_ASSERT_NOW(a_on_pump, out_valid && on_phase, pump_on)
    `FPPS_ASSERT_NOW(a_rest_pump, out_valid && sequencer_state == SEQ_REST, !pump_on)

    // A stalled result word stays put.
    `FPPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(word_bits))

endmodule

bind fuel_pump_prime_sequencer fpps_checker u_fpps_checker (.*);

@@ tb/sv/fuel_pump_prime_sequencer_tb.sv @@
// Self-checking testbench for the fuel pump prime sequencer.
module fuel_pump_prime_sequencer_tb;
    import fpps_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int MAX_REPORTS = 50;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 4'd15;

    typedef struct packed {
        logic        pump_on;
        logic        periodic_enable;
        logic        precontrol_ok;
        logic [2:0]  sequencer_state;
        logic [15:0] ticks_left;
        logic        init_done_flag;
        logic        after_stall_flag;
    } tick_result_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    tick_t drv = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic pump_on;
    logic periodic_enable;
    logic precontrol_ok;
    logic [2:0] sequencer_state;
    logic [15:0] ticks_left;
    logic init_done_flag;
    logic after_stall_flag;

    fuel_pump_prime_sequencer u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .engine_speed      (drv.engine_speed),
        .speed_threshold   (drv.speed_threshold),
        .power_state       (drv.power_state),
        .prep_request      (drv.prep_request),
        .key_on            (drv.key_on),
        .pump_count        (drv.pump_count),
        .precontrol_active (drv.precontrol_active),
        .set_after_stall   (drv.set_after_stall),
        .set_init_done     (drv.set_init_done),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pump_on           (pump_on),
        .periodic_enable   (periodic_enable),
        .precontrol_ok     (precontrol_ok),
        .sequencer_state   (sequencer_state),
        .ticks_left        (ticks_left),
        .init_done_flag    (init_done_flag),
        .after_stall_flag  (after_stall_flag)
    );

    // Shadow of the block: registers and sequencer state
    logic [7:0]  sh_run_speed = 8'd0;
    logic [15:0] sh_on_time = 16'd1;
    logic [15:0] sh_off_time = 16'd1;
    logic [3:0]  sh_antic = 4'd0;
    seq_t        sh_seq = SEQ_WAIT;
    logic [15:0] sh_count = 16'd0;
    logic        sh_pump = 1'b0;
    logic        sh_pc_flag = 1'b0;
    logic        sh_init = 1'b0;
    logic        sh_stall = 1'b0;

    tick_t ticks_to_send[$];
    tick_result_t tick_results_due[$];

    int errors = 0;
    int ticks_sent = 0;
    int results_checked = 0;
    int settings_used = 0;
    logic [5:0] states_seen = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] phase_start(input logic [15:0] len);
        logic [15:0] eff;
        eff = len;
        if (eff == 16'd0)
            eff = 16'd1;
        if (eff > PHASE_MAX)
            eff = PHASE_MAX;
        return eff - 16'd1;
    endfunction

    function automatic logic [15:0] tick_down(input logic [15:0] c);
        logic [15:0] nxt;
        if (c == 16'd0)
            return 16'd0;
        nxt = c - 16'd1;
        return (nxt > PHASE_MAX) ? PHASE_MAX : nxt;
    endfunction

    // Advance the shadow by one task tick and return the word it should produce.
    function automatic tick_result_t prime_tick(input tick_t t);
        logic running;
        logic remote;
        logic en;
        tick_result_t r;
        if (t.set_after_stall)
            sh_stall = 1'b1;
        if (t.set_init_done)
            sh_init = 1'b1;
        if (t.engine_speed > t.speed_threshold)
            sh_pc_flag = 1'b1;
        running = t.engine_speed > sh_run_speed;
        if (running)
            sh_pump = 1'b1;
        remote = (t.power_state == sh_antic) && t.prep_request;
        en = !running && (remote || t.key_on);
        if (!remote && !t.key_on)
            sh_pump = 1'b0;
        case (sh_seq)
            SEQ_WAIT:
            begin
                if (en && t.pump_count == 8'd0 && t.precontrol_active)
                begin
                    if (sh_stall)
                    begin
                        sh_seq = SEQ_STALL;
                        sh_count = tick_down(sh_count);
                    end
                    else if (sh_init)
                    begin
                        sh_seq = SEQ_NOM;
                        sh_count = tick_down(sh_count);
                    end
                    else
                    begin
                        sh_seq = SEQ_KEYON;
                        sh_pump = 1'b1;
                        sh_count = phase_start(sh_on_time);
                    end
                end
            end
            SEQ_STALL, SEQ_NOM, SEQ_REST, SEQ_ON, SEQ_KEYON:
            begin
                if (!en || sh_count == 16'd0)
                begin
                    if (sh_seq == SEQ_STALL)
                        sh_stall = 1'b0;
                    if (sh_seq == SEQ_NOM)
                    begin
                        sh_pc_flag = 1'b0;
                        sh_init = 1'b0;
                    end
                end
                if (!en)
                begin
                    // Enable lost: clear the counter, leave the pump as it is
                    sh_count = 16'd0;
                    sh_seq = SEQ_WAIT;
                end
                else if (sh_count == 16'd0)
                begin
                    if (sh_seq == SEQ_REST)
                    begin
                        sh_pump = 1'b1;
                        sh_seq = SEQ_ON;
                        sh_count = phase_start(sh_on_time);
                    end
                    else
                    begin
                        sh_pump = 1'b0;
                        sh_seq = SEQ_REST;
                        sh_count = phase_start(sh_off_time);
                    end
                end
                else
                    sh_count = tick_down(sh_count);
            end
            default:
                sh_seq = SEQ_WAIT;
        endcase
        r.pump_on = sh_pump;
        r.periodic_enable = en;
        r.precontrol_ok = sh_pc_flag;
        r.sequencer_state = sh_seq;
        r.ticks_left = sh_count;
        r.init_done_flag = sh_init;
        r.after_stall_flag = sh_stall;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Input side: present queued words, hold while stalled
    int send_gap = 0;
    int send_burst = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
            send_burst <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                tick_result_t exp_word;
                exp_word = prime_tick(drv);
                tick_results_due.push_back(exp_word);
                states_seen[exp_word.sequencer_state] <= 1'b1;
                ticks_sent <= ticks_sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (ticks_to_send.size() != 0)
                begin
                    drv <= ticks_to_send.pop_front();
                    in_valid <= 1'b1;
                    if (send_burst > 0)
                    begin
                        send_gap <= 0;
                        send_burst <= send_burst - 1;
                    end
                    else
                    begin
                        send_gap <= pick_gap();
                        if ($urandom_range(0, 99) < 3)
                            send_burst <= $urandom_range(30, 120);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    // Output side: random stall, check each word against the oldest expectation
    int hold_left = 0;
    int calm_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            calm_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                tick_result_t want;
                if (tick_results_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected", $time);
                end
                else
                begin
                    want = tick_results_due.pop_front();
                    compare_field("pump_on", 16'(want.pump_on), 16'(pump_on));
                    compare_field("periodic_enable", 16'(want.periodic_enable),
                                  16'(periodic_enable));
                    compare_field("precontrol_ok", 16'(want.precontrol_ok),
                                  16'(precontrol_ok));
                    compare_field("sequencer_state", 16'(want.sequencer_state),
                                  16'(sequencer_state));
                    compare_field("ticks_left", want.ticks_left, ticks_left);
                    compare_field("init_done_flag", 16'(want.init_done_flag),
                                  16'(init_done_flag));
                    compare_field("after_stall_flag", 16'(want.after_stall_flag),
                                  16'(after_stall_flag));
                    results_checked <= results_checked + 1;
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (calm_left > 0)
                    calm_left <= calm_left - 1;
                else if ($urandom_range(0, 99) < 2)
                    calm_left <= $urandom_range(30, 150);
                else if ($urandom_range(0, 99) < 25)
                    hold_left <= pick_gap();
            end
        end
    end

    // Give up if nothing moves for too long
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RUN_SPEED:  sh_run_speed = data[7:0];
            REG_ON_TIME:    sh_on_time = data;
            REG_OFF_TIME:   sh_off_time = data;
            REG_ANTIC_CODE: sh_antic = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] run_spd, input logic [15:0] on_len,
                              input logic [15:0] off_len, input logic [3:0] antic);
        write_reg(REG_RUN_SPEED, {8'd0, run_spd});
        write_reg(REG_ON_TIME, on_len);
        write_reg(REG_OFF_TIME, off_len);
        write_reg(REG_ANTIC_CODE, {12'd0, antic});
        settings_used++;
    endtask

    // Let every queued word through and every result back, then settle;
    // sample between edges so the handshake of the last edge has settled
    task automatic drain();
        while (ticks_to_send.size() != 0 || tick_results_due.size() != 0 || in_valid)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic tick_t mk(input logic [7:0] spd, input logic [7:0] thr,
                                 input logic [3:0] ps, input logic prep,
                                 input logic key, input logic [7:0] pcnt,
                                 input logic pact, input logic sas, input logic sid);
        tick_t t;
        t.engine_speed = spd;
        t.speed_threshold = thr;
        t.power_state = ps;
        t.prep_request = prep;
        t.key_on = key;
        t.pump_count = pcnt;
        t.precontrol_active = pact;
        t.set_after_stall = sas;
        t.set_init_done = sid;
        return t;
    endfunction

    // Mostly runs that keep priming enabled, broken up by bursts of noise
    task automatic queue_ticks(input int count);
        int left;
        int len;
        logic by_remote;
        logic [63:0] raw;
        tick_t t;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                len = $urandom_range(5, 40);
                by_remote = ($urandom_range(0, 2) == 0);
                for (int i = 0; i < len && left > 0; i++)
                begin
                    raw = {$urandom, $urandom};
                    t = raw[$bits(tick_t)-1:0];
                    t.engine_speed = 8'($urandom_range(0, sh_run_speed));
                    if (by_remote)
                    begin
                        t.power_state = sh_antic;
                        t.prep_request = 1'b1;
                    end
                    else
                        t.key_on = 1'b1;
                    t.pump_count = ($urandom_range(0, 99) < 95) ? 8'd0 : t.pump_count;
                    t.precontrol_active = ($urandom_range(0, 99) < 95);
                    t.set_after_stall = ($urandom_range(0, 99) < 4);
                    t.set_init_done = ($urandom_range(0, 99) < 6);
                    ticks_to_send.push_back(t);
                    left--;
                end
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len && left > 0; i++)
                begin
                    raw = {$urandom, $urandom};
                    ticks_to_send.push_back(raw[$bits(tick_t)-1:0]);
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part under the reset settings
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0));
        ticks_to_send.push_back(mk(8'd255, 8'd255, 4'd15, 1'b1, 1'b1, 8'd255, 1'b1,
                                   1'b1, 1'b1));
        // Remote start with after-stall set: stall, rest, on, rest
        repeat (4)
            ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd0, 1'b1, 1'b0, 8'd0, 1'b1,
                                       1'b0, 1'b0));
        // Drop enable in rest, then nominal entry and loss of enable there
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd3, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0));
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd3, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0, 1'b0));
        ticks_to_send.push_back(mk(8'd5, 8'd9, 4'd3, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0, 1'b0));
        // Key-on first phase, then rest
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd3, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0, 1'b0));
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd3, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0, 1'b0));
        ticks_to_send.push_back(mk(8'd5, 8'd0, 4'd3, 1'b0, 1'b1, 8'd0, 1'b1, 1'b1, 1'b0));
        // Blocked by pump counter and by supervisor
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd3, 1'b0, 1'b1, 8'd7, 1'b1, 1'b0, 1'b0));
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd3, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0));
        // Stall entry, then enable lost in stall
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd3, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0, 1'b0));
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd3, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0));
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd9, 1'b1, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0));
        ticks_to_send.push_back(mk(8'd200, 8'd199, 4'd0, 1'b0, 1'b1, 8'd1, 1'b1,
                                   1'b0, 1'b1));
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd15, 1'b0, 1'b1, 8'd128, 1'b0,
                                   1'b0, 1'b0));
        ticks_to_send.push_back(mk(8'd0, 8'd0, 4'd0, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0, 1'b0));
        drain();

        // Zero phase lengths act as one; never running
        set_config(8'd255, 16'd0, 16'd0, 4'd15);
        queue_ticks(200);
        drain();

        // Writes to indexes past the last register must change nothing
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h5A5A);
        set_config(8'd100, 16'd3, 16'd5, 4'd7);
        queue_ticks(220);
        drain();

        // Over-long phases clamp
        set_config(8'd200, 16'd65535, 16'd65001, 4'd0);
        queue_ticks(60);
        drain();
        set_config(8'd60, 16'd65000, 16'd2, 4'd12);
        queue_ticks(60);
        drain();

        set_config(8'd0, 16'd1, 16'd2, 4'd5);
        queue_ticks(150);
        drain();

        repeat (6)
        begin
            set_config(8'($urandom_range(0, 255)), 16'($urandom_range(1, 12)),
                       16'($urandom_range(1, 12)), 4'($urandom_range(0, 15)));
            queue_ticks(160);
            drain();
        end

        repeat (10) @(posedge clk);
        if (tick_results_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, tick_results_due.size());
        end
        $display("Covered %0d ticks over %0d register settings, %0d words checked.",
                 ticks_sent, settings_used, results_checked);
        $display("Sequencer states reached (bit per state): %b", states_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ fuel_pump_prime_sequencer.f @@
+incdir+design
design/fpps_pkg.sv
design/fpps_step.sv
design/fuel_pump_prime_sequencer.sv
design/fpps_checker.sv
tb/sv/fuel_pump_prime_sequencer_tb.sv
